>>> design/rtpjb_pkg.sv
// shared types and constants for the rtp reorder jitter buffer
package rtpjb_pkg;

  localparam int SEQ_W        = 16;
  localparam int SID_W        = 32;
  localparam int HANDLE_W     = 8;
  localparam int HOLD_W       = 5;
  localparam int CNT_W        = 5;
  localparam int MAX_RELEASES = 22;
  localparam logic [SEQ_W-1:0]  OLD_LIMIT  = 16'd32768;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 5'd10;

  // one stored packet
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SEQ_W-1:0]    seq;
  } slot_entry_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_TEST,
    S_CHECK,
    S_FLUSH
  } seq_state_t;

endpackage

>>> design/rtpjb_slot_ram.sv
// slot ring storage: one write port, one registered read port
module rtpjb_slot_ram #(
  parameter int DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  rtpjb_pkg::slot_entry_t    wr_data,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output rtpjb_pkg::slot_entry_t    rd_data
);

  rtpjb_pkg::slot_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/rtp_reorder_jitter_buffer.sv
// rtp reorder jitter buffer: top level with the drain sequencer
// flow: the item is decoded after acceptance, then each ring slot visited (at most SLOTS) is read,
//   then compared, followed by a final test state and a flush state
// a new item is taken only in idle, once the last one is done; a dropped or restarting item
//   returns to idle after decode; a result side stall holds the compare and flush states
// reset: synchronous rst clears sequencer, window state and slot valid bits; hold_depth 10
module rtp_reorder_jitter_buffer #(
  parameter int SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // packet_seq[15:0], stream_id[47:16], packet_handle[55:48]
  // released packets
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_handle[7:0], out_seq[23:8], gap_count[39:24]
  output logic        m_axis_tlast,   // last_of_run
  // hold_depth register
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);

  localparam int IW = $clog2(SLOTS);        // slot index width
  localparam int AW = $clog2(SLOTS + 1);    // ahead distance width, holds SLOTS itself
  localparam int SW = AW + 1;               // width of bottom + ahead before wrap

  localparam int SEQ_W    = rtpjb_pkg::SEQ_W;
  localparam int SID_W    = rtpjb_pkg::SID_W;
  localparam int HANDLE_W = rtpjb_pkg::HANDLE_W;
  localparam int CNT_W    = rtpjb_pkg::CNT_W;

  // sequencer
  rtpjb_pkg::seq_state_t state, state_next;

  // latched input item
  logic [SEQ_W-1:0]    in_seq;
  logic [SID_W-1:0]    in_sid;
  logic [HANDLE_W-1:0] in_handle;

  // window state
  logic                started;
  logic [SID_W-1:0]    locked_stream;
  logic [SEQ_W-1:0]    expected_seq;
  logic [IW-1:0]       ring_bottom;
  logic [SEQ_W-1:0]    last_released_seq;
  logic                have_released;
  logic [rtpjb_pkg::HOLD_W-1:0] hold_depth;
  logic [SLOTS-1:0]    slot_valid;

  // drain loop
  logic [AW-1:0]       ahead_cnt;
  logic [CNT_W-1:0]    n_count;
  logic                rd_valid;
  rtpjb_pkg::slot_entry_t rd_entry;

  // one release held back so the final one of a run can carry tlast
  logic                pend_valid;
  logic [HANDLE_W-1:0] pend_handle;
  logic [SEQ_W-1:0]    pend_seq;
  logic [SEQ_W-1:0]    pend_gap;

  // output register
  logic [HANDLE_W-1:0] out_handle;
  logic [SEQ_W-1:0]    out_seq;
  logic [SEQ_W-1:0]    gap_count;

  // decode of the latched item (the shared subtract/compare unit)
  logic [SEQ_W-1:0] seq_diff;
  logic             is_foreign, is_old, is_far;
  logic [SW-1:0]    put_sum;
  logic [IW-1:0]    put_idx;

  // ram port control
  logic                   wr_en, rd_en;
  logic [IW-1:0]          wr_addr;
  rtpjb_pkg::slot_entry_t wr_data;

  // loop control
  logic             drain_go, hit, out_busy, check_stall, flush_stall, out_load;
  logic [IW-1:0]    bottom_inc;
  logic [SEQ_W-1:0] hit_gap;

  always_comb begin
    seq_diff   = in_seq - expected_seq;
    is_foreign = (in_sid != locked_stream);
    is_old     = (seq_diff > rtpjb_pkg::OLD_LIMIT);
    is_far     = (seq_diff > SEQ_W'(SLOTS));
    // slot for the packet: bottom plus distance, wrapped once
    put_sum = SW'(ring_bottom) + SW'(seq_diff[AW-1:0]);
    if (put_sum >= SW'(SLOTS)) begin
      put_sum = put_sum - SW'(SLOTS);
    end
    put_idx = put_sum[IW-1:0];
  end

  always_comb begin
    drain_go = ({{(SEQ_W-AW){1'b0}}, ahead_cnt} >
                {{(SEQ_W-rtpjb_pkg::HOLD_W){1'b0}}, hold_depth}) &&
               (n_count < CNT_W'(rtpjb_pkg::MAX_RELEASES));
    hit         = rd_valid && (rd_entry.seq == expected_seq);
    out_busy    = m_axis_tvalid && !m_axis_tready;
    check_stall = hit && pend_valid && out_busy;
    flush_stall = pend_valid && out_busy;
    // output register takes a held release this cycle
    out_load    = pend_valid && !out_busy &&
                  (((state == rtpjb_pkg::S_CHECK) && hit) || (state == rtpjb_pkg::S_FLUSH));
    bottom_inc  = (ring_bottom == IW'(SLOTS - 1)) ? '0 : ring_bottom + IW'(1);
    // first release ever reports no gap
    hit_gap     = have_released ? (rd_entry.seq - last_released_seq - SEQ_W'(1)) : '0;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rtpjb_pkg::S_IDLE: begin
        if (s_axis_tvalid) state_next = rtpjb_pkg::S_EVAL;
      end
      rtpjb_pkg::S_EVAL: begin
        // first packet, foreign, old and far-ahead packets end here
        if (!started || is_foreign || is_old || is_far) state_next = rtpjb_pkg::S_IDLE;
        else state_next = rtpjb_pkg::S_TEST;
      end
      rtpjb_pkg::S_TEST: begin
        state_next = drain_go ? rtpjb_pkg::S_CHECK : rtpjb_pkg::S_FLUSH;
      end
      rtpjb_pkg::S_CHECK: begin
        if (!check_stall) state_next = rtpjb_pkg::S_TEST;
      end
      rtpjb_pkg::S_FLUSH: begin
        if (!flush_stall) state_next = rtpjb_pkg::S_IDLE;
      end
      default: state_next = rtpjb_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = (state == rtpjb_pkg::S_IDLE);
    wr_en   = (state == rtpjb_pkg::S_EVAL) && (!started || (!is_foreign && !is_old));
    // restart (first or far-ahead packet) lands in slot 0
    wr_addr = (!started || is_far) ? '0 : put_idx;
    wr_data.handle = in_handle;
    wr_data.seq    = in_seq;
    rd_en   = (state == rtpjb_pkg::S_TEST) && drain_go;
  end

  rtpjb_slot_ram #(
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (ring_bottom),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= rtpjb_pkg::S_IDLE;
      started           <= 1'b0;
      locked_stream     <= '0;
      expected_seq      <= '0;
      ring_bottom       <= '0;
      last_released_seq <= '0;
      have_released     <= 1'b0;
      hold_depth        <= rtpjb_pkg::HOLD_RESET;
      slot_valid        <= '0;
      ahead_cnt         <= '0;
      n_count           <= '0;
      rd_valid          <= 1'b0;
      pend_valid        <= 1'b0;
      m_axis_tvalid     <= 1'b0;
      m_axis_tlast      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) hold_depth <= cfg_wdata;
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (wr_en) slot_valid[wr_addr] <= 1'b1;

      case (state)
        rtpjb_pkg::S_IDLE: begin
          if (s_axis_tvalid) begin
            in_seq    <= s_axis_tdata[15:0];
            in_sid    <= s_axis_tdata[47:16];
            in_handle <= s_axis_tdata[55:48];
          end
        end
        rtpjb_pkg::S_EVAL: begin
          if (!started) begin
            // first packet locks the stream and opens the window
            started       <= 1'b1;
            locked_stream <= in_sid;
            expected_seq  <= in_seq;
            ring_bottom   <= '0;
          end else if (!is_foreign && !is_old) begin
            if (is_far) begin
              // far ahead: reopen the window, stream stays locked
              expected_seq <= in_seq;
              ring_bottom  <= '0;
            end else begin
              ahead_cnt <= seq_diff[AW-1:0];
              n_count   <= '0;
            end
          end
        end
        rtpjb_pkg::S_TEST: begin
          if (drain_go) rd_valid <= slot_valid[ring_bottom];
        end
        rtpjb_pkg::S_CHECK: begin
          if (!check_stall) begin
            ring_bottom  <= bottom_inc;
            expected_seq <= expected_seq + SEQ_W'(1);
            ahead_cnt    <= ahead_cnt - AW'(1);
            if (hit) begin
              // an earlier release of this run goes out without tlast
              if (pend_valid) begin
                out_handle    <= pend_handle;
                out_seq       <= pend_seq;
                gap_count     <= pend_gap;
                m_axis_tlast  <= 1'b0;
              end
              pend_valid        <= 1'b1;
              pend_handle       <= rd_entry.handle;
              pend_seq          <= rd_entry.seq;
              pend_gap          <= hit_gap;
              last_released_seq <= rd_entry.seq;
              have_released     <= 1'b1;
              n_count           <= n_count + CNT_W'(1);
            end
          end
        end
        rtpjb_pkg::S_FLUSH: begin
          // final release of the run carries tlast
          if (pend_valid && !out_busy) begin
            out_handle    <= pend_handle;
            out_seq       <= pend_seq;
            gap_count     <= pend_gap;
            m_axis_tlast  <= 1'b1;
            pend_valid    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {gap_count, out_seq, out_handle};

`ifndef NO_ASSERTIONS
  // nothing is held back once the block takes a new item
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !pend_valid)
    else $error("held release left over while idle");

  // release budget per item
  a_budget: assert property (@(posedge clk) disable iff (rst)
    n_count <= CNT_W'(rtpjb_pkg::MAX_RELEASES))
    else $error("release budget exceeded");

  // ring bottom stays inside the ring
  a_bottom_range: assert property (@(posedge clk) disable iff (rst)
    ring_bottom <= IW'(SLOTS - 1))
    else $error("ring bottom out of range");

  // a slot compare always follows a slot read
  a_check_after_read: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (state == rtpjb_pkg::S_CHECK))
    else $error("slot read not followed by compare");
`endif

endmodule
